// ----- rtl/symbolic_mode_parser_defines.svh -----
// Assertion macros for the symbolic mode parser.
// Included by symbolic_mode_parser.sv, which carries the concurrent checks; no dependencies.
`ifndef SYMBOLIC_MODE_PARSER_DEFINES_SVH
`define SYMBOLIC_MODE_PARSER_DEFINES_SVH

// Clocked check with asynchronous active-low reset and a caller message.
`define SMP_ASSERT_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same check with a stock message.
`define SMP_ASSERT(label, clk, rst_n, prop) \
  `SMP_ASSERT_MSG(label, clk, rst_n, prop, "symbolic mode parser check failed")

`endif

// ----- rtl/smp_pkg.sv -----
// Types and constants for the symbolic mode parser.
// Used by smp_parser and symbolic_mode_parser; no dependencies.
`default_nettype none

package smp_pkg;

  // Parser phase, one-hot
  typedef enum logic [6:0] {
    PH_OCTAL = 7'b0000001,
    PH_WHO   = 7'b0000010,
    PH_OP    = 7'b0000100,
    PH_SRC   = 7'b0001000,
    PH_PERM  = 7'b0010000,
    PH_SKIP  = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_SET  = 2'd3
  } op_e;

  localparam logic [11:0] M_USER   = 12'o5700;
  localparam logic [11:0] M_GROUP  = 12'o2070;
  localparam logic [11:0] M_OTHER  = 12'o0007;
  localparam logic [11:0] M_ALL    = 12'o1777;
  localparam logic [11:0] M_READ   = 12'o0444;
  localparam logic [11:0] M_WRITE  = 12'o0222;
  localparam logic [11:0] M_EXEC   = 12'o0111;
  localparam logic [11:0] M_SETID  = 12'o6000;
  localparam logic [11:0] M_STICKY = 12'o1000;
  localparam logic [15:0] M_ISDIR  = 16'o040000;

  localparam logic [8:0] UMASK_RESET = 9'o022;

  typedef struct packed {
    logic [7:0]  ch;
    logic        start_req;
    logic [15:0] orig_mode;
  } in_t;

  typedef struct packed {
    logic [15:0] new_mode;
    logic        invalid;
  } out_t;

  // Outcome of one parser step
  typedef struct packed {
    logic emit;
    out_t result;
  } step_t;

endpackage

`default_nettype wire

// ----- rtl/smp_parser.sv -----
// Parser state registers and the combinational step logic for one character.
// Depends on smp_pkg.
`default_nettype none

module smp_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire smp_pkg::in_t  item_i,
  input  wire logic [8:0]    umask_i,
  output smp_pkg::step_t     step_o
);

  typedef struct packed {
    smp_pkg::phase_e phase;
    logic [15:0]     octal_value;
    logic [11:0]     who_mask;
    smp_pkg::op_e    pending_op;
    logic [11:0]     perm_bits;
    logic [15:0]     work_mode;
    logic            error_seen;
  } state_t;

  state_t state_q, state_d;

  function automatic logic [15:0] apply_op(logic [15:0] wm, logic [11:0] who,
                                           logic [11:0] perm, smp_pkg::op_e op);
    logic [15:0] sel;
    logic [15:0] res;
    sel = {4'b0, perm & who};
    res = wm;
    unique case (op)
      smp_pkg::OP_NONE: res = wm;
      smp_pkg::OP_ADD:  res = wm | sel;
      smp_pkg::OP_SUB:  res = wm & ~sel;
      smp_pkg::OP_SET:  res = (wm & ~{4'b0, who}) | sel;
    endcase
    return res;
  endfunction

  // Copy source: source triplet (plus any setid or sticky bit its mask shifts into the rwx window) into u, g and o
  function automatic logic [11:0] copy_bits(logic [7:0] c, logic [15:0] wm);
    logic [11:0] t;
    if (c == "u") begin
      t = 12'((wm[11:0] & smp_pkg::M_USER) >> 6);
    end else if (c == "g") begin
      t = 12'((wm[11:0] & smp_pkg::M_GROUP) >> 3);
    end else begin
      t = wm[11:0] & smp_pkg::M_OTHER;
    end
    t = t & (smp_pkg::M_READ | smp_pkg::M_WRITE | smp_pkg::M_EXEC);
    return t | (t << 3) | (t << 6);
  endfunction

  logic [7:0] ch;
  logic       go_who, go_perm, go_op;
  logic       is_who, is_perm, is_src, is_digit;

  assign ch       = item_i.ch;
  assign is_digit = (ch >= "0") && (ch <= "7");
  assign is_who   = (ch == "u") || (ch == "g") || (ch == "o") || (ch == "a");
  assign is_src   = (ch == "u") || (ch == "g") || (ch == "o");
  assign is_perm  = (ch == "r") || (ch == "w") || (ch == "x") || (ch == "X") ||
                    (ch == "s") || (ch == "t");

  always_comb begin
    state_d = state_q;
    if (item_i.start_req) begin
      state_d.phase       = smp_pkg::PH_OCTAL;
      state_d.octal_value = '0;
      state_d.who_mask    = '0;
      state_d.pending_op  = smp_pkg::OP_NONE;
      state_d.perm_bits   = '0;
      state_d.work_mode   = item_i.orig_mode;
      state_d.error_seen  = 1'b0;
    end
    step_o  = '0;
    go_who  = 1'b0;
    go_perm = 1'b0;
    go_op   = 1'b0;

    unique case (state_d.phase)
      smp_pkg::PH_OCTAL: begin
        if (is_digit) begin
          state_d.octal_value = {state_d.octal_value[12:0], ch[2:0]};
        end else if (ch == 8'd0) begin
          step_o.emit            = 1'b1;
          step_o.result.new_mode = state_d.octal_value;
          state_d.phase          = smp_pkg::PH_DONE;
        end else begin
          state_d.who_mask = '0;
          go_who           = 1'b1;
        end
      end
      smp_pkg::PH_WHO:  go_who = 1'b1;
      smp_pkg::PH_OP:   go_op  = 1'b1;
      smp_pkg::PH_SRC: begin
        if (is_src) begin
          state_d.perm_bits  = copy_bits(ch, state_d.work_mode);
          state_d.work_mode  = apply_op(state_d.work_mode, state_d.who_mask,
                                        state_d.perm_bits, state_d.pending_op);
          state_d.pending_op = smp_pkg::OP_NONE;
          state_d.phase      = smp_pkg::PH_OP;
        end else begin
          go_perm = 1'b1;
        end
      end
      smp_pkg::PH_PERM: go_perm = 1'b1;
      smp_pkg::PH_SKIP: begin
        if (ch == 8'd0) begin
          step_o.emit            = 1'b1;
          step_o.result.new_mode = state_d.work_mode;
          step_o.result.invalid  = state_d.error_seen;
          state_d.phase          = smp_pkg::PH_DONE;
        end
      end
      smp_pkg::PH_DONE: ;
      default: ;
    endcase

    if (go_who) begin
      if (is_who) begin
        priority if (ch == "u") state_d.who_mask = state_d.who_mask | smp_pkg::M_USER;
        else if (ch == "g")     state_d.who_mask = state_d.who_mask | smp_pkg::M_GROUP;
        else if (ch == "o")     state_d.who_mask = state_d.who_mask | smp_pkg::M_OTHER;
        else                    state_d.who_mask = state_d.who_mask | smp_pkg::M_ALL;
        state_d.phase = smp_pkg::PH_WHO;
      end else begin
        if (state_d.who_mask == '0) begin
          state_d.who_mask = smp_pkg::M_ALL & ~{3'b0, umask_i};
        end
        go_op = 1'b1;
      end
    end

    if (go_perm) begin
      if (is_perm) begin
        priority if (ch == "r") state_d.perm_bits = state_d.perm_bits | smp_pkg::M_READ;
        else if (ch == "w")     state_d.perm_bits = state_d.perm_bits | smp_pkg::M_WRITE;
        else if (ch == "x")     state_d.perm_bits = state_d.perm_bits | smp_pkg::M_EXEC;
        else if (ch == "X") begin
          if ((state_d.work_mode & smp_pkg::M_ISDIR) != '0 ||
              (state_d.work_mode[11:0] & smp_pkg::M_EXEC) != '0) begin
            state_d.perm_bits = state_d.perm_bits | smp_pkg::M_EXEC;
          end
        end
        else if (ch == "s")     state_d.perm_bits = state_d.perm_bits | smp_pkg::M_SETID;
        else                    state_d.perm_bits = state_d.perm_bits | smp_pkg::M_STICKY;
        state_d.phase = smp_pkg::PH_PERM;
      end else begin
        state_d.work_mode  = apply_op(state_d.work_mode, state_d.who_mask,
                                      state_d.perm_bits, state_d.pending_op);
        state_d.pending_op = smp_pkg::OP_NONE;
        go_op              = 1'b1;
      end
    end

    if (go_op) begin
      if (ch == "+" || ch == "-" || ch == "=") begin
        priority if (ch == "+") state_d.pending_op = smp_pkg::OP_ADD;
        else if (ch == "-")     state_d.pending_op = smp_pkg::OP_SUB;
        else                    state_d.pending_op = smp_pkg::OP_SET;
        state_d.perm_bits = '0;
        state_d.phase     = smp_pkg::PH_SRC;
      end else if (ch == ",") begin
        state_d.who_mask = '0;
        state_d.phase    = smp_pkg::PH_WHO;
      end else if (ch == 8'd0) begin
        step_o.emit            = 1'b1;
        step_o.result.new_mode = state_d.work_mode;
        step_o.result.invalid  = 1'b0;
        state_d.phase          = smp_pkg::PH_DONE;
      end else begin
        state_d.error_seen = 1'b1;
        state_d.phase      = smp_pkg::PH_SKIP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= smp_pkg::PH_OCTAL;
      state_q.octal_value <= '0;
      state_q.who_mask    <= '0;
      state_q.pending_op  <= smp_pkg::OP_NONE;
      state_q.perm_bits   <= '0;
      state_q.work_mode   <= '0;
      state_q.error_seen  <= 1'b0;
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/symbolic_mode_parser.sv -----
// A NUL character's result goes through the input and result registers to out_valid_o.
// One character per cycle, set by the parser step on its state, unless a result is held.
// Input register, parser step and result register; the result register parts the channels.
// Reset (rst_ni, async, active low): parser in octal phase with zero mode, umask 0022,
// both pipeline registers empty.
// Depends on smp_pkg, smp_parser and symbolic_mode_parser_defines.svh.
`default_nettype none
`include "symbolic_mode_parser_defines.svh"

module symbolic_mode_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire smp_pkg::in_t  in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output smp_pkg::out_t      out_item_o,
  input  wire logic          cfg_we_i,
  input  wire logic [8:0]    cfg_wdata_i
);

  logic           s1_valid_q;
  smp_pkg::in_t   s1_item_q;
  logic           out_valid_q;
  smp_pkg::out_t  out_item_q;
  logic [8:0]     umask_q;
  smp_pkg::step_t step;
  logic           out_free, s1_fire, out_load;

  smp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (s1_fire),
    .item_i  (s1_item_q),
    .umask_i (umask_q),
    .step_o  (step)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!step.emit || out_free);
  assign out_load   = s1_fire && step.emit;
  assign in_ready_o = !s1_valid_q || s1_fire;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      umask_q <= smp_pkg::UMASK_RESET;
    end else if (cfg_we_i) begin
      umask_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= step.result;
    end
  end

  // A blocked character stays in the input register untouched
  `SMP_ASSERT(a_s1_hold, clk_i, rst_ni,
              s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_item_q))
  // A finishing character always lands in the result register
  `SMP_ASSERT(a_emit_lands, clk_i, rst_ni, out_load |=> out_valid_q)
  // Input stalls only behind a result that cannot move
  `SMP_ASSERT_MSG(a_stall_cause, clk_i, rst_ni,
                  !in_ready_o |-> s1_valid_q && step.emit && out_valid_q && !out_ready_i,
                  "input stalled without a blocked result")

endmodule

`default_nettype wire

// ----- dv/symbolic_mode_parser_tb.sv -----
// Self-checking bench for symbolic_mode_parser: mode strings go in one character per transaction,
// and each result is checked against a parser model kept inside the bench.
// Depends on smp_pkg and the symbolic_mode_parser RTL.
`timescale 1ns / 100ps

module symbolic_mode_parser_tb;

  localparam int CLK_PERIOD    = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_STRETCH  = 150;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_SEVEN = "7";
  localparam logic [7:0] CH_ADD   = "+";
  localparam logic [7:0] CH_SUB   = "-";
  localparam logic [7:0] CH_SET   = "=";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_G     = "g";
  localparam logic [7:0] CH_O     = "o";
  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_R     = "r";
  localparam logic [7:0] CH_W     = "w";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_BIG_X = "X";
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_T     = "t";
  localparam logic [7:0] CH_HIGH  = 8'hFF;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  smp_pkg::in_t  in_item_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  smp_pkg::out_t out_item_o;
  logic          cfg_we_i    = 1'b0;
  logic [8:0]    cfg_wdata_i = '0;

  symbolic_mode_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Parser model state
  smp_pkg::phase_e st_phase     = smp_pkg::PH_OCTAL;
  logic [15:0]     st_octal     = '0;
  logic [11:0]     st_who       = '0;
  smp_pkg::op_e    st_op        = smp_pkg::OP_NONE;
  logic [11:0]     st_perm      = '0;
  logic [15:0]     st_mode      = '0;
  logic            st_bad       = 1'b0;
  logic [8:0]      umask_shadow = smp_pkg::UMASK_RESET;

  smp_pkg::in_t   mode_chars[$];
  smp_pkg::out_t  mode_results_due[$];
  smp_pkg::step_t taken_step;
  smp_pkg::out_t  due;

  int mismatches     = 0;
  int quiet_cycles   = 0;
  int chars_queued   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit hold_arm       = 1'b0;

  bit          first_char = 1'b0;
  logic [15:0] first_mode = '0;

  string who_letters  = "ugoa";
  string op_letters   = "+-=";
  string perm_letters = "rwxXst";

  function automatic smp_pkg::step_t finish_string(logic [15:0] mode, logic bad);
    smp_pkg::step_t step;
    step = '0;
    step.emit            = 1'b1;
    step.result.new_mode = mode;
    step.result.invalid  = bad;
    st_phase             = smp_pkg::PH_DONE;
    return step;
  endfunction

  function automatic void apply_pending_op();
    logic [15:0] sel;
    sel = {4'b0, st_perm & st_who};
    case (st_op)
      smp_pkg::OP_ADD: st_mode = st_mode | sel;
      smp_pkg::OP_SUB: st_mode = st_mode & ~sel;
      smp_pkg::OP_SET: st_mode = (st_mode & ~{4'b0, st_who}) | sel;
      default: ;
    endcase
    st_op = smp_pkg::OP_NONE;
  endfunction

  // One character through the parser model; a phase change may re-examine the same character
  function automatic smp_pkg::step_t parse_mode_char(smp_pkg::in_t item);
    smp_pkg::step_t step;
    logic [7:0]     c;
    logic [15:0]    copied;
    bit             again;
    step = '0;
    c    = item.ch;
    if (item.start_req) begin
      st_phase = smp_pkg::PH_OCTAL;
      st_octal = '0;
      st_who   = '0;
      st_op    = smp_pkg::OP_NONE;
      st_perm  = '0;
      st_mode  = item.orig_mode;
      st_bad   = 1'b0;
    end
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (st_phase)
        smp_pkg::PH_OCTAL: begin
          if (c >= CH_ZERO && c <= CH_SEVEN) begin
            st_octal = (st_octal << 3) | 16'(c - CH_ZERO);
          end else if (c == CH_NUL) begin
            step = finish_string(st_octal, 1'b0);
          end else begin
            st_who   = '0;
            st_phase = smp_pkg::PH_WHO;
            again    = 1'b1;
          end
        end
        smp_pkg::PH_WHO: begin
          case (c)
            CH_U: st_who = st_who | smp_pkg::M_USER;
            CH_G: st_who = st_who | smp_pkg::M_GROUP;
            CH_O: st_who = st_who | smp_pkg::M_OTHER;
            CH_A: st_who = st_who | smp_pkg::M_ALL;
            default: begin
              if (st_who == '0) st_who = smp_pkg::M_ALL & ~{3'b0, umask_shadow};
              st_phase = smp_pkg::PH_OP;
              again    = 1'b1;
            end
          endcase
        end
        smp_pkg::PH_OP: begin
          if (c == CH_ADD || c == CH_SUB || c == CH_SET) begin
            st_op    = (c == CH_ADD) ? smp_pkg::OP_ADD :
                       (c == CH_SUB) ? smp_pkg::OP_SUB : smp_pkg::OP_SET;
            st_perm  = '0;
            st_phase = smp_pkg::PH_SRC;
          end else if (c == CH_COMMA) begin
            st_who   = '0;
            st_phase = smp_pkg::PH_WHO;
          end else if (c == CH_NUL) begin
            step = finish_string(st_mode, 1'b0);
          end else begin
            st_bad   = 1'b1;
            st_phase = smp_pkg::PH_SKIP;
          end
        end
        smp_pkg::PH_SRC: begin
          if (c == CH_U || c == CH_G || c == CH_O) begin
            if (c == CH_U) begin
              copied = (st_mode & {4'b0, smp_pkg::M_USER}) >> 6;
            end else if (c == CH_G) begin
              copied = (st_mode & {4'b0, smp_pkg::M_GROUP}) >> 3;
            end else begin
              copied = st_mode & {4'b0, smp_pkg::M_OTHER};
            end
            // setid and sticky bits shifted into the rwx window survive this mask
            copied   = copied &
                       {4'b0, smp_pkg::M_READ | smp_pkg::M_WRITE | smp_pkg::M_EXEC};
            copied   = copied | (copied << 3) | (copied << 6);
            st_perm  = copied[11:0];
            apply_pending_op();
            st_phase = smp_pkg::PH_OP;
          end else begin
            st_phase = smp_pkg::PH_PERM;
            again    = 1'b1;
          end
        end
        smp_pkg::PH_PERM: begin
          case (c)
            CH_R: st_perm = st_perm | smp_pkg::M_READ;
            CH_W: st_perm = st_perm | smp_pkg::M_WRITE;
            CH_X: st_perm = st_perm | smp_pkg::M_EXEC;
            CH_BIG_X: begin
              if ((st_mode & smp_pkg::M_ISDIR) != '0 ||
                  (st_mode[11:0] & smp_pkg::M_EXEC) != '0)
                st_perm = st_perm | smp_pkg::M_EXEC;
            end
            CH_S: st_perm = st_perm | smp_pkg::M_SETID;
            CH_T: st_perm = st_perm | smp_pkg::M_STICKY;
            default: begin
              apply_pending_op();
              st_phase = smp_pkg::PH_OP;
              again    = 1'b1;
            end
          endcase
        end
        smp_pkg::PH_SKIP: begin
          if (c == CH_NUL) step = finish_string(st_mode, st_bad);
        end
        default: ;
      endcase
    end
    return step;
  endfunction

  // Driver: offers queued characters, predicts on each accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        taken_step = parse_mode_char(in_item_i);
        if (taken_step.emit) mode_results_due.push_back(taken_step.result);
      end
      if (!in_valid_i || in_ready_o) begin
        if (mode_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item_i  <= mode_chars.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results in order and drives the receiver's ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (mode_results_due.size() == 0) begin
          $error("result with nothing expected: new_mode %06o invalid %0b",
                 out_item_o.new_mode, out_item_o.invalid);
          mismatches++;
        end else begin
          due = mode_results_due.pop_front();
          if (out_item_o.new_mode !== due.new_mode) begin
            $error("new_mode: expected %06o, got %06o", due.new_mode, out_item_o.new_mode);
            mismatches++;
          end
          if (out_item_o.invalid !== due.invalid) begin
            $error("invalid: expected %0b, got %0b", due.invalid, out_item_o.invalid);
            mismatches++;
          end
        end
      end
      if (hold_arm) begin
        hold_arm  = 1'b0;
        hold_left = HOLD_STRETCH;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("symbolic_mode_parser verification failed");
      $finish;
    end
  end

  task automatic open_string(logic [15:0] mode);
    first_char = 1'b1;
    first_mode = mode;
  endtask

  task automatic put_char(logic [7:0] ch);
    smp_pkg::in_t item;
    item.ch        = ch;
    item.start_req = first_char;
    item.orig_mode = first_char ? first_mode : 16'($urandom);
    first_char     = 1'b0;
    mode_chars.push_back(item);
    chars_queued++;
  endtask

  task automatic put_text(string text);
    for (int i = 0; i < text.len(); i++) put_char(text[i]);
    put_char(CH_NUL);
  endtask

  task automatic put_noisy(logic [7:0] ch);
    if ($urandom_range(99) < 3) put_char(8'($urandom));
    put_char(ch);
  endtask

  // Mostly well-formed clauses with random content; some octal strings, noise and cut strings
  task automatic queue_random_string();
    open_string(16'($urandom));
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(0, 7)) put_noisy(CH_ZERO + 8'($urandom_range(7)));
    end else begin
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) put_noisy(CH_ZERO + 8'($urandom_range(7)));
      for (int k = $urandom_range(1, 3); k > 0; k--) begin
        repeat ($urandom_range(0, 3)) put_noisy(who_letters[$urandom_range(3)]);
        repeat ($urandom_range(1, 3)) begin
          put_noisy(op_letters[$urandom_range(2)]);
          if ($urandom_range(3) == 0)
            put_noisy(who_letters[$urandom_range(2)]);
          else
            repeat ($urandom_range(0, 4)) put_noisy(perm_letters[$urandom_range(5)]);
        end
        if (k > 1) put_noisy(CH_COMMA);
      end
    end
    // an unterminated string gets restarted by the next one
    if ($urandom_range(19) != 0) put_char(CH_NUL);
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 2)) put_char(8'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (mode_chars.size() != 0 || in_valid_i || mode_results_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_umask(logic [8:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    umask_shadow = value;
    @(negedge clk_i);
  endtask

  task automatic run_phase(int items, int send_pct, int recv_pct, logic [8:0] umask,
                           bit squeeze);
    int target;
    wait_idle();
    write_umask(umask);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) hold_arm = 1'b1;
    target = chars_queued + items;
    while (chars_queued < target) queue_random_string();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // parsing before any start flag, from a zero mode
    put_char("5");
    put_char(CH_NUL);
    open_string(16'hFFFF);
    put_char(CH_NUL);
    open_string(16'($urandom));
    put_text("777777");
    open_string(16'o040644);
    put_text("a+X");
    open_string(16'o100750);
    put_text("o=u");
    // bare operator with the default who, then a group clause
    open_string(16'o107777);
    put_text("=,g-rs+xt");
    // unparsable byte, then a trailing character with no start flag
    open_string(16'h0000);
    put_char(CH_U);
    put_char(CH_ADD);
    put_char(CH_HIGH);
    put_char(CH_NUL);
    put_char(CH_X);

    run_phase(200, 0, 0, 9'o000, 1'b0);
    run_phase(200, 79, 0, 9'o777, 1'b0);
    run_phase(200, 0, 79, 9'($urandom), 1'b0);
    run_phase(300, 7, 7, 9'($urandom), 1'b0);
    run_phase(150, 0, 0, smp_pkg::UMASK_RESET, 1'b1);

    wait_idle();
    if (mismatches == 0 && mode_results_due.size() == 0) begin
      $display("symbolic_mode_parser verification clean");
    end else begin
      $display("symbolic_mode_parser verification failed");
    end
    $finish;
  end

endmodule

// ----- symbolic_mode_parser.f -----
+incdir+rtl
rtl/smp_pkg.sv
rtl/smp_parser.sv
rtl/symbolic_mode_parser.sv
dv/symbolic_mode_parser_tb.sv
